// File: src/delta_packed_offset_table_unit_macros.svh
// ----------------------------------------------------------------------------
// delta packed offset table: assertion macros
// immediate-antecedent and next-cycle forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef DELTA_PACKED_OFFSET_TABLE_UNIT_MACROS_SVH
`define DELTA_PACKED_OFFSET_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DPOT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dpot assertion failed");

`define DPOT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dpot assertion failed");

`else

`define DPOT_ASSERT_IMP(label, clk, rstn, ante, cons)

`define DPOT_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: src/dpot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpot_pkg
// word types, command and status codes and packed-field helpers shared by
// the delta packed offset table
// ----------------------------------------------------------------------------
package dpot_pkg;

    localparam int GROUP_WORDS = 5;
    localparam int WORD_W      = 64;
    localparam int OFF_W       = 32;
    localparam int POS_W       = 12;
    localparam int CFG_W       = 13;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_DELTA  = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_UNWRITTEN  = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [OFF_W-1:0] first_offset_in;
        logic [OFF_W-1:0] second_offset_in;
        logic [POS_W-1:0] position;
    } dpot_in_t;

    typedef struct packed {
        logic [OFF_W-1:0] first_offset_out;
        logic [OFF_W-1:0] second_offset_out;
        logic [1:0]       status;
    } dpot_out_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [OFF_W-1:0] x_lo;
        logic [OFF_W-1:0] x_hi;
        logic [OFF_W-1:0] y_lo;
        logic [OFF_W-1:0] y_hi;
    } alu_req_t;

    typedef struct packed {
        logic [OFF_W:0] r_lo;
        logic [OFF_W:0] r_hi;
    } alu_rsp_t;

    // rank of an 8-bit delta among the twelve short fields of a group
    function automatic logic [3:0] delta_rank(input logic [3:0] slot);
        logic [3:0] r;
        unique case (slot)
            4'd1:    r = 4'd0;
            4'd2:    r = 4'd1;
            4'd3:    r = 4'd2;
            4'd5:    r = 4'd3;
            4'd6:    r = 4'd4;
            4'd7:    r = 4'd5;
            4'd9:    r = 4'd6;
            4'd10:   r = 4'd7;
            4'd11:   r = 4'd8;
            4'd13:   r = 4'd9;
            4'd14:   r = 4'd10;
            4'd15:   r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] word_off(input logic [3:0] slot);
        logic [3:0] r;
        r = delta_rank(slot);
        if (slot == 4'd0) begin
            return 3'd0;
        end else if (slot[1:0] == 2'd0) begin
            return 3'd1;
        end else begin
            return 3'd2 + {1'b0, r[3:2]};
        end
    endfunction

    function automatic logic [4:0] field_shift(input logic [3:0] slot);
        logic [3:0] r;
        r = delta_rank(slot);
        if (slot == 4'd0) begin
            return 5'd0;
        end else if (slot[1:0] == 2'd0) begin
            unique case (slot[3:2])
                2'd2:    return 5'd10;
                2'd3:    return 5'd20;
                default: return 5'd0;
            endcase
        end else begin
            return {r[1:0], 3'b000};
        end
    endfunction

    function automatic logic [OFF_W-1:0] field_of(input logic [WORD_W-1:0] word,
                                                  input logic [3:0] slot,
                                                  input logic hi);
        logic [OFF_W-1:0] half;
        logic [OFF_W-1:0] sh;
        half = hi ? word[WORD_W-1:OFF_W] : word[OFF_W-1:0];
        sh   = half >> field_shift(slot);
        if (slot == 4'd0) begin
            return half;
        end else if (slot[1:0] == 2'd0) begin
            return {22'd0, sh[9:0]};
        end else begin
            return {24'd0, sh[7:0]};
        end
    endfunction

    // deltas are already range checked, so the shift never spills past the half
    function automatic logic [WORD_W-1:0] place(input logic [3:0] slot,
                                                input logic [OFF_W-1:0] da,
                                                input logic [OFF_W-1:0] db);
        logic [4:0] s;
        s = field_shift(slot);
        return {db << s, da << s};
    endfunction

    // first entry of a group to land in each packed word
    function automatic logic first_in_word(input logic [3:0] slot);
        return (slot == 4'd0) || (slot == 4'd4) || (slot == 4'd1) ||
               (slot == 4'd6) || (slot == 4'd11);
    endfunction

    function automatic logic [3:0] prev_slot(input logic [3:0] slot);
        return (slot[1:0] == 2'd0) ? slot - 4'd4 : slot - 4'd1;
    endfunction

    // k-th entry along the chain of a slot whose long-step count is q
    function automatic logic [3:0] chain_slot(input logic [2:0] k, input logic [1:0] q);
        logic [2:0] d;
        d = k - {1'b0, q};
        if (k == 3'd0) begin
            return 4'd0;
        end else if (k <= {1'b0, q}) begin
            return {k[1:0], 2'b00};
        end else begin
            return {q, 2'b00} + {1'b0, d};
        end
    endfunction

endpackage
`default_nettype wire

// File: src/dpot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpot_store
// packed word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module dpot_store #(
    parameter int DEPTH  = 1280,
    parameter int AW     = 11,
    parameter int DATA_W = 64
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: src/dpot_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpot_alu
// shared add / subtract unit for both offset halves, carry or borrow in msb
// ----------------------------------------------------------------------------
module dpot_alu (
    input  wire dpot_pkg::alu_req_t req,
    output dpot_pkg::alu_rsp_t      rsp
);
    import dpot_pkg::*;

    always_comb begin
        unique case (req.op)
            ALU_SUB: begin
                rsp.r_lo = {1'b0, req.x_lo} - {1'b0, req.y_lo};
                rsp.r_hi = {1'b0, req.x_hi} - {1'b0, req.y_hi};
            end
            default: begin
                rsp.r_lo = {1'b0, req.x_lo} + {1'b0, req.y_lo};
                rsp.r_hi = {1'b0, req.x_hi} + {1'b0, req.y_hi};
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/delta_packed_offset_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_packed_offset_table_unit
// append-only table of offset pairs, sixteen entries to a group of five
// delta-packed 64-bit words, with lookup by chained delta sums
// ----------------------------------------------------------------------------
// One word at a time. A clear, an unused command, a rejected append and a
// lookup of an unwritten position go from the decode state straight to the
// done state. A stored append does a read-modify-write of one packed word
// through the single memory, a read state then a write state. A lookup makes
// one memory read and one pass through the shared adder for each link of the
// delta chain, n+1 links for n = slot/4 + slot%4, slot = position mod 16. The
// done state loads the output register, and waits while the result there is
// not yet taken. A new word is taken while the previous result still waits
// on the output register. No clearing pass: each packed word is overwritten
// by the first entry that lands in it after a clear.
// ----------------------------------------------------------------------------
module delta_packed_offset_table_unit #(
    parameter int MAX_ENTRIES = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire dpot_pkg::dpot_in_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output dpot_pkg::dpot_out_t                   m_data,
    input  wire logic                             cfg_we,
    input  wire logic [dpot_pkg::CFG_W-1:0]       cfg_wdata
);
    import dpot_pkg::*;

`include "delta_packed_offset_table_unit_macros.svh"

    localparam int CW         = $clog2(MAX_ENTRIES + 1);
    localparam int IW         = (CW > POS_W) ? CW : POS_W;
    localparam int GW         = IW - 4;
    localparam int NUM_GROUPS = MAX_ENTRIES / 16;
    localparam int DEPTH      = NUM_GROUPS * GROUP_WORDS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_APP_RD,
        S_APP_WR,
        S_LK_RD,
        S_LK_ACC,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [1:0]        cmd_reg;
    logic [OFF_W-1:0]  a_reg;
    logic [OFF_W-1:0]  b_reg;
    logic [IW-1:0]     idx_reg;
    logic [WORD_W-1:0] prev_pair_reg;
    logic [OFF_W-1:0]  da_reg;
    logic [OFF_W-1:0]  db_reg;
    logic [OFF_W-1:0]  acc_lo_reg;
    logic [OFF_W-1:0]  acc_hi_reg;
    logic [2:0]        k_reg;
    logic [1:0]        res_st_reg;
    logic [CW-1:0]     entry_count_reg;
    logic [CW-1:0]     cap_reg;
    logic              m_valid_reg;
    dpot_out_t         m_data_reg;

    logic [WORD_W-1:0] recent_pairs [16];

    logic [3:0]        slot;
    logic [GW-1:0]     grp;
    logic [GW+2:0]     grp_x5;
    logic [AW-1:0]     base_addr;
    logic [AW-1:0]     mem_addr;
    logic [3:0]        cur_slot;
    logic [2:0]        chain_len;
    logic              lk_busy;
    logic              grp_ok;
    logic              delta_bad;
    logic              in_accept;
    logic [CFG_W:0]    cfg_round;
    logic [CW-1:0]     cap_new;
    logic              rd_en;
    logic              wr_en;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] wr_data;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign slot      = idx_reg[3:0];
    assign grp       = idx_reg[IW-1:4];
    assign grp_x5    = {1'b0, grp, 2'b00} + {3'b000, grp};
    assign base_addr = AW'(grp_x5);
    assign grp_ok    = grp < GW'(NUM_GROUPS);
    assign chain_len = {1'b0, slot[3:2]} + {1'b0, slot[1:0]};
    assign lk_busy   = (state_reg == S_LK_RD) || (state_reg == S_LK_ACC);
    assign cur_slot  = lk_busy ? chain_slot(k_reg, slot[3:2]) : slot;
    assign mem_addr  = base_addr + AW'(word_off(cur_slot));

    // capacity rounded up to a whole group, then held at the table size
    assign cfg_round = ({1'b0, cfg_wdata} + (CFG_W + 1)'(15)) & ~((CFG_W + 1)'(15));
    assign cap_new   = (32'(cfg_round) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) :
                       CW'(cfg_round);

    always_comb begin
        if (state_reg == S_DECODE) begin
            alu_req.op   = ALU_SUB;
            alu_req.x_lo = a_reg;
            alu_req.x_hi = b_reg;
            alu_req.y_lo = prev_pair_reg[OFF_W-1:0];
            alu_req.y_hi = prev_pair_reg[WORD_W-1:OFF_W];
        end else begin
            alu_req.op   = ALU_ADD;
            alu_req.x_lo = acc_lo_reg;
            alu_req.x_hi = acc_hi_reg;
            alu_req.y_lo = field_of(rd_data, cur_slot, 1'b0);
            alu_req.y_hi = field_of(rd_data, cur_slot, 1'b1);
        end
    end

    // borrow means the value sits below its chain base; a delta too wide for its 10-bit or 8-bit field is also bad
    always_comb begin
        if (slot[1:0] == 2'd0) begin
            delta_bad = alu_rsp.r_lo[OFF_W] || alu_rsp.r_hi[OFF_W] ||
                        (|alu_rsp.r_lo[OFF_W-1:10]) || (|alu_rsp.r_hi[OFF_W-1:10]);
        end else begin
            delta_bad = alu_rsp.r_lo[OFF_W] || alu_rsp.r_hi[OFF_W] ||
                        (|alu_rsp.r_lo[OFF_W-1:8]) || (|alu_rsp.r_hi[OFF_W-1:8]);
        end
    end

    assign rd_en   = (state_reg == S_APP_RD) || (state_reg == S_LK_RD);
    assign wr_en   = (state_reg == S_APP_WR);
    assign wr_data = (first_in_word(slot) ? '0 : rd_data) | place(slot, da_reg, db_reg);

    dpot_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    dpot_store #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .DATA_W (WORD_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (mem_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (mem_addr),
        .wr_data (wr_data)
    );

    // last pair of each slot, base for the next delta
    always_ff @(posedge aclk) begin
        if (state_reg == S_APP_WR) begin
            recent_pairs[slot] <= {b_reg, a_reg};
        end
        if (in_accept) begin
            prev_pair_reg <= recent_pairs[prev_slot(entry_count_reg[3:0])];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            cap_reg         <= CW'(MAX_ENTRIES);
            m_valid_reg     <= 1'b0;
        end else begin
            // in the done state the output register is reloaded instead
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                cap_reg         <= cap_new;
                entry_count_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_data.cmd;
                        a_reg     <= s_data.first_offset_in;
                        b_reg     <= s_data.second_offset_in;
                        idx_reg   <= (s_data.cmd == CMD_APPEND) ? IW'(entry_count_reg) :
                                     IW'(s_data.position);
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    acc_lo_reg <= '0;
                    acc_hi_reg <= '0;
                    k_reg      <= '0;
                    da_reg     <= (slot == 4'd0) ? a_reg : alu_rsp.r_lo[OFF_W-1:0];
                    db_reg     <= (slot == 4'd0) ? b_reg : alu_rsp.r_hi[OFF_W-1:0];
                    unique case (cmd_reg)
                        CMD_APPEND: begin
                            if (entry_count_reg >= cap_reg) begin
                                res_st_reg <= ST_FULL;
                                state_reg  <= S_DONE;
                            end else if ((slot != 4'd0) && delta_bad) begin
                                res_st_reg <= ST_BAD_DELTA;
                                state_reg  <= S_DONE;
                            end else if (!grp_ok) begin
                                res_st_reg <= ST_FULL;
                                state_reg  <= S_DONE;
                            end else begin
                                res_st_reg <= ST_OK;
                                state_reg  <= S_APP_RD;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (idx_reg >= IW'(entry_count_reg)) begin
                                res_st_reg <= ST_UNWRITTEN;
                                state_reg  <= S_DONE;
                            end else begin
                                res_st_reg <= ST_OK;
                                state_reg  <= S_LK_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            entry_count_reg <= '0;
                            res_st_reg      <= ST_OK;
                            state_reg       <= S_DONE;
                        end
                        default: begin
                            res_st_reg <= ST_OK;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end
                S_APP_RD: begin
                    state_reg <= S_APP_WR;
                end
                S_APP_WR: begin
                    entry_count_reg <= entry_count_reg + CW'(1);
                    state_reg       <= S_DONE;
                end
                S_LK_RD: begin
                    state_reg <= S_LK_ACC;
                end
                S_LK_ACC: begin
                    acc_lo_reg <= alu_rsp.r_lo[OFF_W-1:0];
                    acc_hi_reg <= alu_rsp.r_hi[OFF_W-1:0];
                    if (k_reg == chain_len) begin
                        state_reg <= S_DONE;
                    end else begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_LK_RD;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                  <= 1'b1;
                        m_data_reg.first_offset_out  <= acc_lo_reg;
                        m_data_reg.second_offset_out <= acc_hi_reg;
                        m_data_reg.status            <= res_st_reg;
                        state_reg                    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `DPOT_ASSERT_IMP(a_count_within_cap, aclk, aresetn, 1'b1, entry_count_reg <= cap_reg)
    `DPOT_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, in_accept, state_reg == S_DECODE)
    `DPOT_ASSERT_IMP(a_chain_bound, aclk, aresetn, lk_busy, k_reg <= chain_len)
    `DPOT_ASSERT_IMP(a_error_zero_pair, aclk, aresetn, m_valid && |m_data.status, m_data[2*OFF_W+1:2] == '0)

endmodule
`default_nettype wire
